// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Single-cycle or temporal check, sampled on clk, idle during reset.
`define RLPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rlps assertion failed");

// Implication form.
`define RLPS_ASSERT_IMP(lbl, ante, cons) \
  `RLPS_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== src/rlps_pkg.sv =====
package rlps_pkg;

  localparam int PROG_DEPTH = 256;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int DIV_STEPS  = 16;

  localparam logic [15:0] SPB_RESET = 16'd15000;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] MODE_FLASH = 2'd0;
  localparam logic [1:0] MODE_FADE  = 2'd1;
  localparam logic [1:0] MODE_UP    = 2'd2;
  localparam logic [1:0] MODE_DOWN  = 2'd3;

  localparam logic [1:0] COLOR_BAD = 2'd3;
  localparam logic [1:0] CH_NONE   = 2'd3;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_COLOR = 2'd1;
  localparam logic [1:0] FLT_RATE  = 2'd2;
  localparam logic [1:0] FLT_SEG   = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] channel;
    logic [7:0] word_address;
    logic [7:0] op_code;
    logic [7:0] step_rate;
    logic [7:0] beat_count;
    logic [7:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  lit_channel;
    logic [7:0]  level;
    logic [15:0] tick_period;
    logic        advanced;
    logic [7:0]  program_index;
    logic [1:0]  fault;
    logic        final_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_DONE,
    ST_LD_RD,
    ST_LD_CHK,
    ST_LD_DIV,
    ST_LD_APPLY,
    ST_TICK,
    ST_EMIT
  } state_t;

endpackage

// ===== src/rlps_ram.sv =====
module rlps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/rlps_div.sv =====
module rlps_div
  import rlps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [15:0] quotient
);

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [15:0]   quo_r, quo_nxt;
  logic [7:0]    dvs_r, dvs_nxt;
  logic [8:0]    trial;
  logic [8:0]    diff;

  assign trial = {rem_r, quo_r[15]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[7:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/rgb_led_pattern_sequencer.sv =====
// Three-channel LED pattern sequencer.
// Input channel (in_valid/in_ready/in_data): one item is a program word write,
// a start request or a timer tick for one channel. in_ready is high only while
// the sequencer is idle; one item is taken at a time.
// Result channel (out_valid/out_ready/out_data): one output register. A tick
// gives one item unless halted or on CH_NONE; start up to three; write none.
// Config channel (cfg_valid/cfg_ready/cfg_data): steps_per_beat, always ready.
// A tick updates the level and, when its count runs out, loads the next
// instruction; a load uses the bit-serial 16/8 divider (16 steps) to compute
// the timer period; a start scans the store word by word until the third
// segment end, then does up to three loads.
// When the receiver stalls, the sequencer holds in its emit step until the
// output register frees; no item is lost.
// Reset (synchronous, rst_n low) clears all channel state, sets rising, clears
// halted and loads steps_per_beat with 15000. The program store has no reset.
module rgb_led_pattern_sequencer
  import rlps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

  state_t state_r, state_nxt;

  logic [15:0] spb_r, spb_nxt;
  logic        halted_r, halted_nxt;

  logic [7:0]  seg_first_r [3];
  logic [7:0]  seg_first_nxt [3];
  logic [7:0]  seg_last_r [3];
  logic [7:0]  seg_last_nxt [3];
  logic [7:0]  cur_idx_r [3];
  logic [7:0]  cur_idx_nxt [3];
  logic [7:0]  lvl_now_r [3];
  logic [7:0]  lvl_now_nxt [3];
  logic [7:0]  lvl_peak_r [3];
  logic [7:0]  lvl_peak_nxt [3];
  logic [3:0]  rstep_r [3];
  logic [3:0]  rstep_nxt [3];
  logic [15:0] acts_r [3];
  logic [15:0] acts_nxt [3];
  logic [15:0] period_r [3];
  logic [15:0] period_nxt [3];
  logic [1:0]  mode_r [3];
  logic [1:0]  mode_nxt [3];
  logic        rising_r [3];
  logic        rising_nxt [3];

  logic [7:0]  fst_r [3];
  logic [7:0]  fst_nxt [3];
  logic [7:0]  lst_r [3];
  logic [7:0]  lst_nxt [3];
  logic [PROG_AW-1:0] scan_i_r, scan_i_nxt;
  logic [1:0]  seg_r, seg_nxt;

  logic [1:0]  sel_r, sel_nxt;
  logic [1:0]  c_r, c_nxt;
  logic        from_start_r, from_start_nxt;
  logic        more_r, more_nxt;
  logic [7:0]  ld_idx_r, ld_idx_nxt;
  logic [31:0] wd_r, wd_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [7:0]  tlvl_r, tlvl_nxt;
  logic [15:0] tper_r, tper_nxt;
  out_item_t   res_r, res_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic               ram_we;
  logic [PROG_AW-1:0] ram_addr;
  logic [31:0]        ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quo;

  logic        in_fire;
  logic        out_free;
  logic [31:0] word;
  logic [7:0]  now, pk, nlvl, st8;
  logic        rise;
  logic [15:0] cnt_dec;
  logic [7:0]  nidx;
  logic [1:0]  col, mode;
  logic [7:0]  br;
  logic [7:0]  new_lvl, new_pk;
  logic [15:0] new_per, new_cnt;

  rlps_ram #(.WIDTH(32), .DEPTH(PROG_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.op_code, in_data.step_rate, in_data.beat_count, in_data.brightness}),
    .rdata (ram_rdata)
  );

  rlps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (spb_r),
    .divisor  (wd_nxt[23:16]),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // per-channel action on the ticking channel
  always_comb begin
    now  = lvl_now_r[sel_r];
    pk   = lvl_peak_r[sel_r];
    st8  = {4'h0, rstep_r[sel_r]};
    rise = rising_r[sel_r];
    nlvl = now;
    case (mode_r[sel_r])
      MODE_FLASH: nlvl = (now == pk) ? 8'h00 : pk;
      MODE_FADE: begin
        if (now >= pk) begin
          rise = 1'b0;
        end else if (now == 8'h00) begin
          rise = 1'b1;
        end
        nlvl = rise ? now + st8 : now - st8;
      end
      MODE_UP:   nlvl = (now >= pk) ? 8'h00 : now + st8;
      default:   nlvl = (now == 8'h00) ? pk : now - st8;
    endcase
    cnt_dec = acts_r[sel_r] - 16'd1;
    nidx = (cur_idx_r[sel_r] == seg_last_r[sel_r]) ? seg_first_r[sel_r]
                                                    : cur_idx_r[sel_r] + 8'd1;
  end

  // instruction decode for the load step
  always_comb begin
    col  = wd_r[31:30];
    mode = wd_r[29:28];
    br   = wd_r[7:0];
    if (mode == MODE_FLASH) begin
      new_pk  = br;
      new_lvl = br;
      new_cnt = {prod_r[14:0], 1'b0};
      new_per = {1'b0, div_quo[15:1]};
    end else begin
      new_pk  = {br[7:4], 4'h0};
      new_lvl = (mode == MODE_DOWN) ? new_pk : 8'h00;
      new_cnt = {prod_r[11:0], 4'h0};
      new_per = {4'h0, div_quo[15:4]};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    spb_nxt        = cfg_valid ? cfg_data : spb_r;
    halted_nxt     = halted_r;
    seg_first_nxt  = seg_first_r;
    seg_last_nxt   = seg_last_r;
    cur_idx_nxt    = cur_idx_r;
    lvl_now_nxt    = lvl_now_r;
    lvl_peak_nxt   = lvl_peak_r;
    rstep_nxt      = rstep_r;
    acts_nxt       = acts_r;
    period_nxt     = period_r;
    mode_nxt       = mode_r;
    rising_nxt     = rising_r;
    fst_nxt        = fst_r;
    lst_nxt        = lst_r;
    scan_i_nxt     = scan_i_r;
    seg_nxt        = seg_r;
    sel_nxt        = sel_r;
    c_nxt          = c_r;
    from_start_nxt = from_start_r;
    more_nxt       = more_r;
    ld_idx_nxt     = ld_idx_r;
    wd_nxt         = wd_r;
    prod_nxt       = prod_r;
    tlvl_nxt       = tlvl_r;
    tper_nxt       = tper_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_we         = 1'b0;
    ram_addr       = ld_idx_r[PROG_AW-1:0];
    div_start      = 1'b0;
    word           = ({1'b0, ld_idx_r} < 9'(PROG_DEPTH)) ? ram_rdata : 32'h0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.req_type)
            REQ_WRITE: begin
              if ({1'b0, in_data.word_address} < 9'(PROG_DEPTH)) begin
                ram_we   = 1'b1;
                ram_addr = in_data.word_address[PROG_AW-1:0];
              end
            end
            REQ_START: begin
              halted_nxt = 1'b0;
              scan_i_nxt = '0;
              seg_nxt    = '0;
              fst_nxt    = '{default: 8'h00};
              lst_nxt    = '{default: 8'h00};
              state_nxt  = ST_SCAN_RD;
            end
            REQ_TICK: begin
              if (!halted_r && in_data.channel != CH_NONE) begin
                sel_nxt   = in_data.channel;
                state_nxt = ST_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        ram_addr  = scan_i_r;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (ram_rdata[24]) begin
          lst_nxt[seg_r] = 8'(scan_i_r);
          if (seg_r != 2'd2) begin
            fst_nxt[2'(seg_r + 2'd1)] = 8'(scan_i_r) + 8'd1;
          end
          seg_nxt = seg_r + 2'd1;
        end
        if (ram_rdata[24] && seg_r == 2'd2) begin
          state_nxt = ST_SCAN_DONE;
        end else if (scan_i_r == PROG_AW'(PROG_DEPTH - 1)) begin
          halted_nxt = 1'b1;
          res_nxt    = '{lit_channel: 2'd0, level: 8'h00, tick_period: 16'h0,
                         advanced: 1'b0, program_index: 8'h00, fault: FLT_SEG,
                         final_result: 1'b1};
          more_nxt   = 1'b0;
          state_nxt  = ST_EMIT;
        end else begin
          scan_i_nxt = scan_i_r + 1'b1;
          state_nxt  = ST_SCAN_RD;
        end
      end
      ST_SCAN_DONE: begin
        seg_first_nxt  = fst_r;
        seg_last_nxt   = lst_r;
        cur_idx_nxt    = fst_r;
        c_nxt          = 2'd0;
        from_start_nxt = 1'b1;
        ld_idx_nxt     = fst_r[0];
        state_nxt      = ST_LD_RD;
      end
      ST_LD_RD: begin
        state_nxt = ST_LD_CHK;
      end
      ST_LD_CHK: begin
        wd_nxt = word;
        if (word[31:30] == COLOR_BAD || word[23:16] == 8'h00) begin
          halted_nxt = 1'b1;
          res_nxt    = '{lit_channel: word[31:30], level: 8'h00, tick_period: 16'h0,
                         advanced: 1'b0, program_index: ld_idx_r,
                         fault: (word[31:30] == COLOR_BAD) ? FLT_COLOR : FLT_RATE,
                         final_result: from_start_r};
          more_nxt   = 1'b0;
          state_nxt  = ST_EMIT;
        end else begin
          div_start = 1'b1;
          prod_nxt  = word[15:8] * word[23:16];
          state_nxt = ST_LD_DIV;
        end
      end
      ST_LD_DIV: begin
        if (div_done) begin
          state_nxt = ST_LD_APPLY;
        end
      end
      ST_LD_APPLY: begin
        mode_nxt[col]     = mode;
        lvl_peak_nxt[col] = new_pk;
        lvl_now_nxt[col]  = new_lvl;
        acts_nxt[col]     = new_cnt;
        period_nxt[col]   = new_per;
        if (mode != MODE_FLASH) begin
          rstep_nxt[col] = br[7:4];
        end
        if (mode == MODE_FADE) begin
          rising_nxt[col] = 1'b1;
        end
        if (from_start_r) begin
          res_nxt  = '{lit_channel: col, level: new_lvl, tick_period: new_per,
                       advanced: 1'b1, program_index: ld_idx_r, fault: FLT_NONE,
                       final_result: (c_r == 2'd2)};
          more_nxt = (c_r != 2'd2);
        end else begin
          res_nxt  = '{lit_channel: sel_r, level: tlvl_r,
                       tick_period: (col == sel_r) ? new_per : tper_r,
                       advanced: 1'b1, program_index: ld_idx_r, fault: FLT_NONE,
                       final_result: 1'b0};
          more_nxt = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_TICK: begin
        lvl_now_nxt[sel_r] = nlvl;
        rising_nxt[sel_r]  = rise;
        acts_nxt[sel_r]    = cnt_dec;
        tlvl_nxt           = nlvl;
        tper_nxt           = period_r[sel_r];
        if (cnt_dec != 16'h0) begin
          res_nxt   = '{lit_channel: sel_r, level: nlvl, tick_period: period_r[sel_r],
                        advanced: 1'b0, program_index: cur_idx_r[sel_r],
                        fault: FLT_NONE, final_result: 1'b0};
          more_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          cur_idx_nxt[sel_r] = nidx;
          ld_idx_nxt         = nidx;
          from_start_nxt     = 1'b0;
          state_nxt          = ST_LD_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          if (more_r) begin
            c_nxt      = c_r + 2'd1;
            ld_idx_nxt = seg_first_r[2'(c_r + 2'd1)];
            state_nxt  = ST_LD_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      spb_r        <= SPB_RESET;
      halted_r     <= 1'b0;
      seg_first_r  <= '{default: 8'h00};
      seg_last_r   <= '{default: 8'h00};
      cur_idx_r    <= '{default: 8'h00};
      lvl_now_r    <= '{default: 8'h00};
      lvl_peak_r   <= '{default: 8'h00};
      rstep_r      <= '{default: 4'h0};
      acts_r       <= '{default: 16'h0};
      period_r     <= '{default: 16'h0};
      mode_r       <= '{default: MODE_FLASH};
      rising_r     <= '{default: 1'b1};
      out_valid_r  <= 1'b0;
      from_start_r <= 1'b0;
      more_r       <= 1'b0;
      c_r          <= 2'd0;
      seg_r        <= 2'd0;
      scan_i_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      spb_r        <= spb_nxt;
      halted_r     <= halted_nxt;
      seg_first_r  <= seg_first_nxt;
      seg_last_r   <= seg_last_nxt;
      cur_idx_r    <= cur_idx_nxt;
      lvl_now_r    <= lvl_now_nxt;
      lvl_peak_r   <= lvl_peak_nxt;
      rstep_r      <= rstep_nxt;
      acts_r       <= acts_nxt;
      period_r     <= period_nxt;
      mode_r       <= mode_nxt;
      rising_r     <= rising_nxt;
      out_valid_r  <= out_valid_nxt;
      from_start_r <= from_start_nxt;
      more_r       <= more_nxt;
      c_r          <= c_nxt;
      seg_r        <= seg_nxt;
      scan_i_r     <= scan_i_nxt;
    end
    fst_r      <= fst_nxt;
    lst_r      <= lst_nxt;
    sel_r      <= sel_nxt;
    ld_idx_r   <= ld_idx_nxt;
    wd_r       <= wd_nxt;
    prod_r     <= prod_nxt;
    tlvl_r     <= tlvl_nxt;
    tper_r     <= tper_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `RLPS_ASSERT_IMP(a_div_done_in_wait, div_done, state_r == ST_LD_DIV)
  `RLPS_ASSERT_IMP(a_seg_fault_final, out_valid_r && out_data_r.fault == FLT_SEG,
                   out_data_r.final_result)
  `RLPS_ASSERT_IMP(a_adv_no_fault, out_valid_r && out_data_r.advanced,
                   out_data_r.fault == FLT_NONE)
  `RLPS_ASSERT_IMP(a_emit_after_free, state_r == ST_EMIT && out_free,
                   ##1 out_valid_r)

endmodule
